FILE: hdl/tccb_pkg.sv
// Shared types and codes for the text console cursor buffer.
`timescale 1ns / 1ps
package tccb_pkg;

    // operation field of an input beat
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // control characters
    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_FF = 8'd12;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] BLANK = 8'd0;

    // command kinds passed from the front end to the execution unit
    typedef logic [2:0] t_kind;
    localparam t_kind K_READ = 3'd0;
    localparam t_kind K_BS   = 3'd1;
    localparam t_kind K_CR   = 3'd2;
    localparam t_kind K_NL   = 3'd3;
    localparam t_kind K_FF   = 3'd4;
    localparam t_kind K_CHAR = 3'd5;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
        logic [4:0] row;
        logic [6:0] col;
    } t_cmd;

endpackage

FILE: hdl/tccb_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
module tccb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/tccb_front.sv
// Front end: accepts input beats, classifies them and queues commands.
`timescale 1ns / 1ps
module tccb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,   // char_code, read_row, read_column, zero pad
    input  logic              i_s_tuser,   // operation
    output logic              o_cmd_valid,
    output tccb_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    tccb_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           w_push;
    tccb_pkg::t_cmd w_cmd;

    assign o_s_tready = i_en && (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        w_cmd.code = i_s_tdata[7:0];
        w_cmd.row  = i_s_tdata[12:8];
        w_cmd.col  = i_s_tdata[19:13];
        case (i_s_tuser)
            tccb_pkg::OP_READ: w_cmd.kind = tccb_pkg::K_READ;
            default: begin
                case (i_s_tdata[7:0])
                    tccb_pkg::CH_BS: w_cmd.kind = tccb_pkg::K_BS;
                    tccb_pkg::CH_CR: w_cmd.kind = tccb_pkg::K_CR;
                    tccb_pkg::CH_NL: w_cmd.kind = tccb_pkg::K_NL;
                    tccb_pkg::CH_FF: w_cmd.kind = tccb_pkg::K_FF;
                    default:         w_cmd.kind = tccb_pkg::K_CHAR;
                endcase
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
endmodule

FILE: hdl/tccb_back.sv
// Execution unit: cursor, configuration, character RAM, scroll and clear sweeps.
`timescale 1ns / 1ps
module tccb_back #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_COLUMNS = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output logic           o_ready_en,
    input  logic           i_cmd_valid,
    input  tccb_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [23:0]    o_m_tdata,   // read_data, cursor_column, cursor_row, zero pad
    output logic           o_m_tuser    // scrolled
);
    localparam int DEPTH    = MAX_ROWS * MAX_COLUMNS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NRW      = $clog2(MAX_ROWS + 1);
    localparam int NCW      = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_RST = (24 > MAX_ROWS) ? MAX_ROWS : 24;
    localparam int COLS_RST = (80 > MAX_COLUMNS) ? MAX_COLUMNS : 80;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_COPY   = 3'd4;
    localparam logic [2:0] S_BLANK  = 3'd5;

    // control state
    logic [2:0]     r_state, n_state;
    logic [AW-1:0]  r_clr_addr, n_clr_addr;
    logic [NRW-1:0] r_rows;
    logic [NCW-1:0] r_cols;
    logic [XW-1:0]  r_cur_x, n_cur_x;
    logic [YW-1:0]  r_cur_y, n_cur_y;
    logic           r_pend, n_pend;
    logic           r_out_valid, n_out_valid;

    // payload
    tccb_pkg::t_cmd r_cmd, n_cmd;
    logic [XW-1:0]  r_x, n_x;
    logic [YW-1:0]  r_y, n_y;
    logic           r_rd_zero, n_rd_zero;
    logic [AW-1:0]  r_base, n_base;
    logic [YW-1:0]  r_row, n_row;
    logic [XW-1:0]  r_col, n_col;
    logic [AW-1:0]  r_pend_addr, n_pend_addr;
    logic           r_scr, n_scr;
    logic [7:0]     r_out_data, n_out_data;
    logic [6:0]     r_out_x, n_out_x;
    logic [4:0]     r_out_y, n_out_y;
    logic           r_out_scr, n_out_scr;

    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [7:0]     w_wdata;
    logic [AW-1:0]  w_raddr;
    logic [7:0]     w_rdata;

    logic [NRW-1:0] w_cfg_rows;
    logic [NCW-1:0] w_cfg_cols;
    logic [XW-1:0]  w_cols_m1;
    logic [YW-1:0]  w_rows_m1;
    logic [YW-1:0]  w_rows_m2;
    logic [XW-1:0]  w_x_clamp;
    logic [YW-1:0]  w_y_clamp;
    logic           w_rd_ok;
    logic [AW-1:0]  w_rd_addr;
    logic           w_pop;
    logic           w_out_take;

    // a zero register value becomes 1 and a value above the maximum saturates to it; rows uses only data bits 5:0
    assign w_cfg_rows = (i_cfg_data[5:0] == 6'd0) ? NRW'(1) :
                        (int'(i_cfg_data[5:0]) > MAX_ROWS) ? NRW'(MAX_ROWS) :
                        NRW'(i_cfg_data[5:0]);
    assign w_cfg_cols = (i_cfg_data == 8'd0) ? NCW'(1) :
                        (int'(i_cfg_data) > MAX_COLUMNS) ? NCW'(MAX_COLUMNS) :
                        NCW'(i_cfg_data);

    assign w_cols_m1 = XW'(r_cols - NCW'(1));
    assign w_rows_m1 = YW'(r_rows - NRW'(1));
    assign w_rows_m2 = YW'(r_rows - NRW'(2));
    assign w_x_clamp = (int'(r_cur_x) >= int'(r_cols)) ? w_cols_m1 : r_cur_x;
    assign w_y_clamp = (int'(r_cur_y) >= int'(r_rows)) ? w_rows_m1 : r_cur_y;

    assign w_rd_ok   = (int'(i_cmd.row) < MAX_ROWS) && (int'(i_cmd.col) < MAX_COLUMNS);
    assign w_rd_addr = AW'(int'(i_cmd.row) * MAX_COLUMNS + int'(i_cmd.col));

    assign w_out_take = r_out_valid && i_m_tready;
    assign w_pop      = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_m_tready);
    assign o_cmd_pop  = w_pop;
    assign o_ready_en = (r_state != S_CLEAR);

    always_comb begin
        logic v_wrap;
        logic v_scroll;
        logic v_ff;

        v_wrap      = 1'b0;
        v_scroll    = 1'b0;
        v_ff        = 1'b0;
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_y         = r_y;
        n_rd_zero   = r_rd_zero;
        n_base      = r_base;
        n_row       = r_row;
        n_col       = r_col;
        n_pend_addr = r_pend_addr;
        n_scr       = r_scr;
        n_out_data  = r_out_data;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_scr   = r_out_scr;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = tccb_pkg::BLANK;
        w_raddr     = w_rd_addr;

        if (w_out_take) begin
            n_out_valid = 1'b0;
        end

        // finish the write of a cell copied during scroll
        if (r_pend) begin
            w_we    = 1'b1;
            w_waddr = r_pend_addr;
            w_wdata = w_rdata;
        end

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = tccb_pkg::BLANK;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_pop) begin
                    n_cmd     = i_cmd;
                    n_x       = w_x_clamp;
                    n_y       = w_y_clamp;
                    n_rd_zero = !w_rd_ok;
                    n_state   = (i_cmd.kind == tccb_pkg::K_READ) ? S_RDWAIT : S_EXEC;
                end
            end
            S_RDWAIT: begin
                n_out_valid = 1'b1;
                n_out_data  = r_rd_zero ? 8'd0 : w_rdata;
                n_out_x     = 7'(r_cur_x);
                n_out_y     = 5'(r_cur_y);
                n_out_scr   = 1'b0;
                n_state     = S_IDLE;
            end
            S_EXEC: begin
                n_cur_x = r_x;
                n_cur_y = r_y;
                case (r_cmd.kind)
                    tccb_pkg::K_BS: begin
                        if (r_x != '0) begin
                            n_cur_x = r_x - XW'(1);
                        end else if (r_y != '0) begin
                            n_cur_y = r_y - YW'(1);
                            n_cur_x = w_cols_m1;
                        end
                    end
                    tccb_pkg::K_CR: begin
                        n_cur_x = '0;
                    end
                    tccb_pkg::K_NL: begin
                        n_cur_x = '0;
                        v_wrap  = 1'b1;
                    end
                    tccb_pkg::K_FF: begin
                        n_cur_x = '0;
                        n_cur_y = '0;
                        v_ff    = 1'b1;
                    end
                    default: begin
                        w_we    = 1'b1;
                        w_waddr = AW'(int'(r_y) * MAX_COLUMNS + int'(r_x));
                        w_wdata = r_cmd.code;
                        if (r_x == w_cols_m1) begin
                            n_cur_x = '0;
                            v_wrap  = 1'b1;
                        end else begin
                            n_cur_x = r_x + XW'(1);
                        end
                    end
                endcase
                if (v_wrap) begin
                    if (r_y == w_rows_m1) begin
                        v_scroll = 1'b1;
                    end else begin
                        n_cur_y = r_y + YW'(1);
                    end
                end
                n_base = '0;
                n_row  = '0;
                n_col  = '0;
                n_scr  = v_scroll;
                if (v_ff) begin
                    n_state = S_BLANK;
                end else if (v_scroll) begin
                    n_state = (r_rows == NRW'(1)) ? S_BLANK : S_COPY;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_data  = 8'd0;
                    n_out_x     = 7'(n_cur_x);
                    n_out_y     = 5'(n_cur_y);
                    n_out_scr   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_COPY: begin
                // read the cell one row below, write it back on the next cycle
                w_raddr     = AW'(int'(r_base) + MAX_COLUMNS + int'(r_col));
                n_pend      = 1'b1;
                n_pend_addr = AW'(int'(r_base) + int'(r_col));
                if (r_col == w_cols_m1) begin
                    n_col  = '0;
                    n_base = AW'(int'(r_base) + MAX_COLUMNS);
                    n_row  = r_row + YW'(1);
                    if (r_row == w_rows_m2) begin
                        n_state = S_BLANK;
                    end
                end else begin
                    n_col = r_col + XW'(1);
                end
            end
            S_BLANK: begin
                if (!r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(int'(r_base) + int'(r_col));
                    w_wdata = tccb_pkg::BLANK;
                    if (r_col == w_cols_m1) begin
                        n_col = '0;
                        if (r_row == w_rows_m1) begin
                            n_out_valid = 1'b1;
                            n_out_data  = 8'd0;
                            n_out_x     = 7'(r_cur_x);
                            n_out_y     = 5'(r_cur_y);
                            n_out_scr   = r_scr;
                            n_state     = S_IDLE;
                        end else begin
                            n_row  = r_row + YW'(1);
                            n_base = AW'(int'(r_base) + MAX_COLUMNS);
                        end
                    end else begin
                        n_col = r_col + XW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rows      <= NRW'(ROWS_RST);
            r_cols      <= NCW'(COLS_RST);
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tccb_pkg::CFG_ROWS: r_rows <= w_cfg_rows;
                    tccb_pkg::CFG_COLS: r_cols <= w_cfg_cols;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_x         <= n_x;
        r_y         <= n_y;
        r_rd_zero   <= n_rd_zero;
        r_base      <= n_base;
        r_row       <= n_row;
        r_col       <= n_col;
        r_pend_addr <= n_pend_addr;
        r_scr       <= n_scr;
        r_out_data  <= n_out_data;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_scr   <= n_out_scr;
    end

    tccb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_y, r_out_x, r_out_data};
    assign o_m_tuser  = r_out_scr;
endmodule

FILE: hdl/text_console_cursor_buffer.sv
// Top level of the text console cursor buffer.
`timescale 1ns / 1ps
// Text-mode character buffer with a cursor. Each input beat is either a put
// (a character or one of backspace, return, newline, form feed) or a read of
// one cell for scan-out; every beat gives exactly one output beat with the
// cell data (0 for a put), the cursor position after the beat and a scroll
// flag. Input beats go into a two-entry command queue, so the input side keeps
// taking beats while a result waits on the output. The character RAM has a
// single write port; a scroll copies one cell per cycle, each row from the
// row below, then blanks the last row, and a form feed blanks every cell of
// the area, with rows and columns the values in use. After reset a clearing
// pass over all MAX_ROWS * MAX_COLUMNS cells (4096 by default) zeroes the
// RAM with s_tready held low; configuration writes are taken at any time but
// must only be issued while the block is idle.
module text_console_cursor_buffer #(
    parameter int MAX_ROWS    = 32,
    parameter int MAX_COLUMNS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // char_code, read_row, read_column, zero pad
    input  logic        i_s_tuser,   // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // read_data, cursor_column, cursor_row, zero pad
    output logic        o_m_tuser    // scrolled
);
    logic           w_ready_en;
    logic           w_cmd_valid;
    tccb_pkg::t_cmd w_cmd;
    logic           w_cmd_pop;

    assign o_cfg_ready = 1'b1;

    tccb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_ready_en),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    tccb_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ready_en  (w_ready_en),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );
endmodule

FILE: hdl/tccb_checker.sv
// Port-level checker for the text console cursor buffer, bound to the top level.
`timescale 1ns / 1ps
module tccb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser
);
    logic [2:0] r_cnt;
    logic       w_in;
    logic       w_out;

    assign w_in  = i_s_tvalid && o_s_tready;
    assign w_out = o_m_tvalid && i_m_tready;

    // beats accepted whose result has not left yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (w_in && !w_out) begin
            r_cnt <= r_cnt + 3'd1;
        end else if (!w_in && w_out) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    a_scroll_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[7:0] == 8'd0)
        else $error("scrolled result carries cell data");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_cnt != 3'd0)
        else $error("result beat without an accepted input beat");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd3)
        else $error("more beats in flight than queue and output can hold");
endmodule

bind text_console_cursor_buffer tccb_checker u_tccb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the text console cursor buffer.
`timescale 1ns / 1ps
module tb_top;

    localparam int GRID_ROWS       = 32;
    localparam int GRID_COLUMNS    = 128;
    localparam int QUIET_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 4200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 64;
    localparam int REPORT_LIMIT    = 10;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] code;
        logic [4:0] row;
        logic [6:0] col;
    } t_console_beat;

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] ccol;
        logic [4:0] crow;
        logic       scrolled;
    } t_cursor_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = 24'd0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;

    text_console_cursor_buffer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the console
    logic [7:0] screen_cells [GRID_ROWS][GRID_COLUMNS];
    logic [6:0] cur_col = 7'd0;
    logic [4:0] cur_row = 5'd0;
    logic [5:0] rows_reg = 6'd24;
    logic [7:0] cols_reg = 8'd80;

    t_console_beat  pending_beats[$];
    t_cursor_report reports_due[$];
    t_idle_mode     idle_mode = IDLE_NONE;
    bit             stall_request = 1'b0;
    bit             in_beat_taken = 1'b0;
    int             beats_issued = 0;
    int             beats_accepted = 0;
    int             error_count = 0;
    int             quiet_cycles = 0;

    function automatic int visible_rows();
        int n;
        n = rows_reg;
        if (n == 0) n = 1;
        if (n > GRID_ROWS) n = GRID_ROWS;
        return n;
    endfunction

    function automatic int visible_cols();
        int n;
        n = cols_reg;
        if (n == 0) n = 1;
        if (n > GRID_COLUMNS) n = GRID_COLUMNS;
        return n;
    endfunction

    task automatic apply_console_beat(input t_console_beat b, output t_cursor_report r);
        int nrows;
        int ncols;
        int x;
        int y;
        r = '0;
        if (b.op == tccb_pkg::OP_READ) begin
            r.data = screen_cells[b.row][b.col];
        end else begin
            nrows = visible_rows();
            ncols = visible_cols();
            x = cur_col;
            y = cur_row;
            // clamp a cursor left outside by a shrunk area
            if (x >= ncols) x = ncols - 1;
            if (y >= nrows) y = nrows - 1;
            case (b.code)
                tccb_pkg::CH_BS: begin
                    if (x != 0) begin
                        x--;
                    end else if (y != 0) begin
                        y--;
                        x = ncols - 1;
                    end
                end
                tccb_pkg::CH_CR: x = 0;
                tccb_pkg::CH_NL: begin
                    x = 0;
                    y++;
                end
                tccb_pkg::CH_FF: begin
                    for (int rr = 0; rr < nrows; rr++)
                        for (int cc = 0; cc < ncols; cc++)
                            screen_cells[rr][cc] = tccb_pkg::BLANK;
                    x = 0;
                    y = 0;
                end
                default: begin
                    screen_cells[y][x] = b.code;
                    x++;
                    if (x == ncols) begin
                        x = 0;
                        y++;
                    end
                end
            endcase
            if (y == nrows) begin
                for (int rr = 0; rr + 1 < nrows; rr++)
                    for (int cc = 0; cc < ncols; cc++)
                        screen_cells[rr][cc] = screen_cells[rr + 1][cc];
                for (int cc = 0; cc < ncols; cc++)
                    screen_cells[nrows - 1][cc] = tccb_pkg::BLANK;
                y = nrows - 1;
                r.scrolled = 1'b1;
            end
            cur_col = x[6:0];
            cur_row = y[4:0];
        end
        r.ccol = cur_col;
        r.crow = cur_row;
    endtask

    function automatic t_console_beat put_beat(input logic [7:0] code);
        t_console_beat b;
        b = '0;
        b.op = tccb_pkg::OP_PUT;
        b.code = code;
        return b;
    endfunction

    function automatic t_console_beat read_beat(input logic [4:0] row, input logic [6:0] col);
        t_console_beat b;
        b = '0;
        b.op = tccb_pkg::OP_READ;
        b.row = row;
        b.col = col;
        return b;
    endfunction

    function automatic t_console_beat random_beat(input int ctrl_pct);
        t_console_beat b;
        int pick;
        int which;
        b.code = 8'($urandom_range(255));
        b.row = 5'($urandom_range(31));
        b.col = 7'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 30) begin
            b.op = tccb_pkg::OP_READ;
            // half the reads are drawn from inside the visible area where text lives
            if ($urandom_range(1) == 0) begin
                b.row = 5'($urandom_range(visible_rows() - 1));
                b.col = 7'($urandom_range(visible_cols() - 1));
            end
        end else begin
            b.op = tccb_pkg::OP_PUT;
            if (pick < 30 + ctrl_pct) begin
                which = $urandom_range(9);
                if (which < 3) b.code = tccb_pkg::CH_BS;
                else if (which < 5) b.code = tccb_pkg::CH_CR;
                else if (which < 9) b.code = tccb_pkg::CH_NL;
                else b.code = tccb_pkg::CH_FF;
            end
        end
        return b;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic queue_beat(input t_console_beat b);
        pending_beats.push_back(b);
        beats_issued++;
    endtask

    task automatic write_console_reg(input logic idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == tccb_pkg::CFG_ROWS) rows_reg = value[5:0];
        else cols_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (beats_accepted != beats_issued || reports_due.size() != 0) @(posedge i_clk);
        // a scroll or clear has finished once its report has left
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_console_phase(input logic [7:0] rows_val, input logic [7:0] cols_val,
                                     input t_idle_mode mode, input int beats,
                                     input int ctrl_pct);
        write_console_reg(tccb_pkg::CFG_ROWS, rows_val);
        write_console_reg(tccb_pkg::CFG_COLS, cols_val);
        idle_mode = mode;
        repeat (beats) queue_beat(random_beat(ctrl_pct));
        drain_and_settle();
    endtask

    task automatic flag_error(input string msg);
        if (error_count < REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // input driver: hold a beat until taken
    always @(negedge i_clk) begin : beat_driver
        t_console_beat b;
        if (!i_s_tvalid || in_beat_taken) begin
            if (pending_beats.size() != 0 &&
                !((idle_mode == IDLE_SEND && roll(57)) ||
                  (idle_mode == IDLE_BOTH && roll(31)))) begin
                b = pending_beats.pop_front();
                i_s_tdata <= {4'd0, b.col, b.row, b.code};
                i_s_tuser <= b.op;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure, with one long hold-off on request
    always @(negedge i_clk) begin : report_sink
        int stall_left;
        bit stall_started;
        if (stall_request && !stall_started) begin
            stall_started = 1'b1;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !((idle_mode == IDLE_RECV && roll(57)) ||
                            (idle_mode == IDLE_BOTH && roll(31)));
        end
    end

    always @(posedge i_clk) begin : beat_monitor
        t_console_beat  b;
        t_cursor_report want;
        t_cursor_report got;
        bit             out_fire;
        in_beat_taken = i_s_tvalid && o_s_tready;
        out_fire = o_m_tvalid && i_m_tready;
        if (in_beat_taken) begin
            b.op = i_s_tuser;
            b.code = i_s_tdata[7:0];
            b.row = i_s_tdata[12:8];
            b.col = i_s_tdata[19:13];
            apply_console_beat(b, want);
            reports_due.push_back(want);
            beats_accepted++;
        end
        if (out_fire) begin
            got.data = o_m_tdata[7:0];
            got.ccol = o_m_tdata[14:8];
            got.crow = o_m_tdata[19:15];
            got.scrolled = o_m_tuser;
            if (reports_due.size() == 0) begin
                flag_error($sformatf("unexpected output beat data=%0d col=%0d row=%0d scr=%0d",
                                     got.data, got.ccol, got.crow, got.scrolled));
            end else begin
                want = reports_due.pop_front();
                if (got !== want)
                    flag_error($sformatf({"mismatch: expected data=%0d col=%0d row=%0d ",
                                          "scr=%0d, got data=%0d col=%0d row=%0d scr=%0d"},
                                         want.data, want.ccol, want.crow, want.scrolled,
                                         got.data, got.ccol, got.crow, got.scrolled));
            end
        end
        if (in_beat_taken || out_fire || (i_cfg_valid && o_cfg_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        for (int rr = 0; rr < GRID_ROWS; rr++)
            for (int cc = 0; cc < GRID_COLUMNS; cc++) screen_cells[rr][cc] = tccb_pkg::BLANK;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default 24 x 80 area: cleared store, extreme codes, backspace at home
        queue_beat(read_beat(5'd0, 7'd0));
        queue_beat(read_beat(5'd31, 7'd127));
        queue_beat(put_beat(tccb_pkg::BLANK));
        queue_beat(put_beat(8'hFF));
        queue_beat(put_beat(tccb_pkg::CH_BS));
        queue_beat(put_beat(tccb_pkg::CH_CR));
        queue_beat(put_beat(tccb_pkg::CH_BS));
        queue_beat(read_beat(5'd0, 7'd0));
        queue_beat(read_beat(5'd0, 7'd1));
        drain_and_settle();

        // tiny 3 x 4 area: backspace across a row, wrap, scroll by newline and by text
        write_console_reg(tccb_pkg::CFG_ROWS, 8'd3);
        write_console_reg(tccb_pkg::CFG_COLS, 8'd4);
        queue_beat(put_beat(tccb_pkg::CH_NL));
        queue_beat(put_beat(tccb_pkg::CH_BS));
        queue_beat(put_beat(8'h41));
        queue_beat(put_beat(tccb_pkg::CH_NL));
        queue_beat(put_beat(tccb_pkg::CH_NL));
        for (int i = 0; i < 4; i++) queue_beat(put_beat(8'h31 + 8'(i)));
        queue_beat(put_beat(tccb_pkg::CH_FF));
        queue_beat(read_beat(5'd0, 7'd3));
        queue_beat(read_beat(5'd1, 7'd0));
        drain_and_settle();

        run_console_phase(8'd4, 8'd8, IDLE_NONE, 200, 20);
        run_console_phase(8'd1, 8'd1, IDLE_SEND, 150, 20);
        run_console_phase(8'd0, 8'd0, IDLE_RECV, 100, 20);
        run_console_phase(8'd5, 8'd128, IDLE_BOTH, 150, 10);
        run_console_phase(8'd63, 8'd255, IDLE_NONE, 80, 4);
        run_console_phase(8'd32, 8'd128, IDLE_SEND, 60, 4);
        // long output hold-off: the input side must back up and stall
        stall_request = 1'b1;
        run_console_phase(8'hC2, 8'd3, IDLE_RECV, 250, 20);
        run_console_phase(8'd7, 8'd6, IDLE_BOTH, 250, 20);
        run_console_phase(8'd6, 8'd129, IDLE_NONE, 150, 10);
        run_console_phase(8'd1, 8'd200, IDLE_SEND, 150, 20);
        run_console_phase(8'd12, 8'd2, IDLE_BOTH, 200, 20);

        while (beats_accepted != beats_issued || reports_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && reports_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/tccb_pkg.sv
hdl/tccb_ram.sv
hdl/tccb_front.sv
hdl/tccb_back.sv
hdl/text_console_cursor_buffer.sv
hdl/tccb_checker.sv
tb/tb_top.sv
